>>> rtl/frw_pkg.sv
package frw_pkg;

    // Stream and grid sizing
    localparam int DATA_W           = 32;
    localparam int CFG_W            = 10;
    localparam int MAX_COARSE_WIDTH = 512;
    localparam int HEIGHT_LIMIT     = 512;
    localparam int LINE_DEPTH       = 2 * MAX_COARSE_WIDTH;
    localparam int ADDR_W           = $clog2(LINE_DEPTH);
    localparam int ROW_W            = $clog2(2 * HEIGHT_LIMIT);
    localparam int CSUM_W           = DATA_W + 2;
    localparam int TSUM_W           = DATA_W + 4;

    // Configuration register indexes
    localparam logic REG_COARSE_WIDTH  = 1'b0;
    localparam logic REG_COARSE_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] COARSE_RESET = CFG_W'(4);

    // Position flags of one fine sample, carried down the pipeline
    typedef struct packed {
        logic              emit;
        logic              boundary;
        logic              last;
        logic [ADDR_W-1:0] addr;
    } pos_info_t;

    // Effective coarse width: zero acts as one, oversize clamps
    function automatic logic [ADDR_W-1:0] clamp_width(input logic [CFG_W-1:0] cfg);
        logic [ADDR_W-1:0] res;
        if (cfg == '0)
            res = ADDR_W'(1);
        else if (int'(cfg) > MAX_COARSE_WIDTH)
            res = ADDR_W'(MAX_COARSE_WIDTH);
        else
            res = ADDR_W'(cfg);
        return res;
    endfunction

    // Effective coarse height: zero acts as one, oversize clamps
    function automatic logic [ROW_W-1:0] clamp_height(input logic [CFG_W-1:0] cfg);
        logic [ROW_W-1:0] res;
        if (cfg == '0)
            res = ROW_W'(1);
        else if (int'(cfg) > HEIGHT_LIMIT)
            res = ROW_W'(HEIGHT_LIMIT);
        else
            res = ROW_W'(cfg);
        return res;
    endfunction

endpackage

>>> rtl/frw_line_mem.sv
module frw_line_mem (
    input  logic                         clk,
    input  logic                         we,
    input  logic [frw_pkg::ADDR_W-1:0]   waddr,
    input  logic [frw_pkg::DATA_W-1:0]   wdata,
    input  logic                         re,
    input  logic [frw_pkg::ADDR_W-1:0]   raddr,
    output logic [frw_pkg::DATA_W-1:0]   rdata
);

    logic [frw_pkg::DATA_W-1:0] mem [frw_pkg::LINE_DEPTH];
    logic [frw_pkg::DATA_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port, holds while not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/frw_addr_gen.sv
module frw_addr_gen (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [frw_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        adv,
    output frw_pkg::pos_info_t          pos
);

    logic [frw_pkg::ADDR_W-1:0] last_col_reg, last_col_next;
    logic [frw_pkg::ROW_W-1:0]  last_row_reg, last_row_next;
    logic [frw_pkg::ADDR_W-2:0] last_j_reg, last_j_next;
    logic [frw_pkg::ROW_W-2:0]  last_i_reg, last_i_next;
    logic [frw_pkg::ADDR_W-1:0] col_reg, col_next;
    logic [frw_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [frw_pkg::ADDR_W-1:0] width_eff;
    logic [frw_pkg::ROW_W-1:0]  height_eff;
    logic [frw_pkg::ADDR_W:0]   fine_w;
    logic [frw_pkg::ROW_W:0]    fine_h;
    logic [frw_pkg::ADDR_W-2:0] coarse_j;
    logic [frw_pkg::ROW_W-2:0]  coarse_i;

    // Derive frame limits from the written register value
    always_comb
    begin
        width_eff  = frw_pkg::clamp_width(cfg_data);
        height_eff = frw_pkg::clamp_height(cfg_data);
        fine_w     = {width_eff, 1'b0} - (frw_pkg::ADDR_W + 1)'(1);
        fine_h     = {height_eff, 1'b0} - (frw_pkg::ROW_W + 1)'(1);
    end

    // Update limits on a register write; any write restarts the frame
    always_comb
    begin
        last_col_next = last_col_reg;
        last_row_next = last_row_reg;
        last_j_next   = last_j_reg;
        last_i_next   = last_i_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        if (cfg_we)
        begin
            col_next = '0;
            row_next = '0;
            case (cfg_index)
                frw_pkg::REG_COARSE_WIDTH:
                begin
                    last_col_next = fine_w[frw_pkg::ADDR_W-1:0];
                    last_j_next   = (frw_pkg::ADDR_W - 1)'(width_eff - frw_pkg::ADDR_W'(1));
                end
                frw_pkg::REG_COARSE_HEIGHT:
                begin
                    last_row_next = fine_h[frw_pkg::ROW_W-1:0];
                    last_i_next   = (frw_pkg::ROW_W - 1)'(height_eff - frw_pkg::ROW_W'(1));
                end
                default:
                begin
                    last_col_next = last_col_reg;
                end
            endcase
        end
        else if (adv)
        begin
            if (col_reg == last_col_reg)
            begin
                col_next = '0;
                row_next = (row_reg == last_row_reg) ? '0 : row_reg + frw_pkg::ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + frw_pkg::ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg <= frw_pkg::ADDR_W'({frw_pkg::clamp_width(frw_pkg::COARSE_RESET), 1'b0}
                            - (frw_pkg::ADDR_W + 1)'(1));
            last_row_reg <= frw_pkg::ROW_W'({frw_pkg::clamp_height(frw_pkg::COARSE_RESET), 1'b0}
                            - (frw_pkg::ROW_W + 1)'(1));
            last_j_reg   <= (frw_pkg::ADDR_W - 1)'(frw_pkg::clamp_width(frw_pkg::COARSE_RESET)
                            - frw_pkg::ADDR_W'(1));
            last_i_reg   <= (frw_pkg::ROW_W - 1)'(frw_pkg::clamp_height(frw_pkg::COARSE_RESET)
                            - frw_pkg::ROW_W'(1));
            col_reg      <= '0;
            row_reg      <= '0;
        end
        else
        begin
            last_col_reg <= last_col_next;
            last_row_reg <= last_row_next;
            last_j_reg   <= last_j_next;
            last_i_reg   <= last_i_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
        end
    end

    // Classify the current fine position
    always_comb
    begin
        coarse_j     = col_reg[frw_pkg::ADDR_W-1:1];
        coarse_i     = row_reg[frw_pkg::ROW_W-1:1];
        pos.addr     = col_reg;
        pos.emit     = row_reg[0] & col_reg[0];
        pos.boundary = (coarse_i == '0) || (coarse_i == last_i_reg)
                    || (coarse_j == '0) || (coarse_j == last_j_reg);
        pos.last     = (coarse_i == last_i_reg) && (coarse_j == last_j_reg);
    end

endmodule

>>> rtl/frw_window.sv
module frw_window (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load_p2,
    input  logic [frw_pkg::DATA_W-1:0]   top_in,
    input  logic [frw_pkg::DATA_W-1:0]   mid_in,
    input  logic [frw_pkg::DATA_W-1:0]   bot_in,
    input  logic                         load_out,
    input  logic                         zero_out,
    output logic [frw_pkg::DATA_W-1:0]   value
);

    logic [frw_pkg::CSUM_W-1:0] col_sum;
    logic [frw_pkg::CSUM_W-1:0] win_old_reg;
    logic [frw_pkg::CSUM_W-1:0] win_prev_reg;
    logic [frw_pkg::CSUM_W-1:0] p2_a_reg;
    logic [frw_pkg::CSUM_W-1:0] p2_b_reg;
    logic [frw_pkg::CSUM_W-1:0] p2_c_reg;
    logic [frw_pkg::TSUM_W-1:0] total;
    logic [frw_pkg::DATA_W-1:0] value_reg;

    // Weighted column sum 1-2-1, sign extended
    assign col_sum = {{2{top_in[frw_pkg::DATA_W-1]}}, top_in}
                   + {mid_in[frw_pkg::DATA_W-1], mid_in, 1'b0}
                   + {{2{bot_in[frw_pkg::DATA_W-1]}}, bot_in};

    // Shift the window of column sums as each sample moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_old_reg  <= '0;
            win_prev_reg <= '0;
        end
        else if (load_p2)
        begin
            win_old_reg  <= win_prev_reg;
            win_prev_reg <= col_sum;
        end
    end

    // Capture the three columns of the stencil
    always_ff @(posedge clk)
    begin
        if (load_p2)
        begin
            p2_a_reg <= win_old_reg;
            p2_b_reg <= win_prev_reg;
            p2_c_reg <= col_sum;
        end
    end

    // Weighted row sum 1-2-1, then floor shift by 4
    assign total = {{2{p2_a_reg[frw_pkg::CSUM_W-1]}}, p2_a_reg}
                 + {p2_b_reg[frw_pkg::CSUM_W-1], p2_b_reg, 1'b0}
                 + {{2{p2_c_reg[frw_pkg::CSUM_W-1]}}, p2_c_reg};

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            value_reg <= zero_out ? '0 : total[frw_pkg::TSUM_W-1:4];
        end
    end

    assign value = value_reg;

endmodule

>>> rtl/full_weighting_restriction_2d_unit.sv
// Full-weighting 2D restriction of a fine grid streamed in raster order.
// Input s_*: one signed Q16.16 fine sample per transaction; the frame has
// 2*coarse_height rows of 2*coarse_width columns. Output m_*: one coarse
// point per fine sample at an odd row and odd column, with tlast on the
// final coarse point. Boundary coarse points are zero.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 coarse
// width, 1 coarse height) and restarts the frame; write only while idle.
// Throughput is one sample per cycle while the output is not stalled. An
// accepted sample reaches m_tdata through the registered line store read
// at the accepting edge, the column sums captured in the stencil
// registers and the row sum entering the output register. The line store
// read-modify-write sets the rate: each sample reads its column and writes
// it back when it moves on to the stencil registers, and consecutive
// samples always fall on different columns.
// When m_tready is low the held result stalls the pipeline only once an
// emitting sample reaches it; samples that emit nothing keep flowing.
// Reset clears position counters, window and valid flags, and sets both
// sizes to 4. Line stores are not cleared; stale entries feed only
// boundary points.
module full_weighting_restriction_2d_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [frw_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [frw_pkg::DATA_W-1:0]  s_tdata,   // [31:0] sample
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [frw_pkg::DATA_W-1:0]  m_tdata,   // [31:0] value
    output logic                        m_tlast
);

    frw_pkg::pos_info_t         pos;
    frw_pkg::pos_info_t         p1_info_reg;
    frw_pkg::pos_info_t         p2_info_reg;
    logic                       p1_valid_reg, p1_valid_next;
    logic                       p2_valid_reg, p2_valid_next;
    logic                       m_valid_reg, m_valid_next;
    logic                       m_last_reg;
    logic [frw_pkg::DATA_W-1:0] p1_sample_reg;
    logic [frw_pkg::DATA_W-1:0] upper_rdata;
    logic [frw_pkg::DATA_W-1:0] lower_rdata;
    logic                       s_acc;
    logic                       out_free;
    logic                       p2_move;
    logic                       p1_move;
    logic                       out_load;
    logic                       mem_we;

    // Flow control: each stage moves when the one after it has room
    always_comb
    begin
        out_free = !m_valid_reg || m_tready;
        p2_move  = !p2_valid_reg || !p2_info_reg.emit || out_free;
        p1_move  = !p1_valid_reg || p2_move;
        s_acc    = s_tvalid && p1_move;
        out_load = p2_valid_reg && p2_info_reg.emit && out_free;
        mem_we   = p1_valid_reg && p2_move;

        p1_valid_next = p1_move ? s_tvalid : p1_valid_reg;
        p2_valid_next = p2_move ? p1_valid_reg : p2_valid_reg;
        if (out_load)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
        else
            m_valid_next = m_valid_reg;
    end

    assign s_tready = p1_move;

    frw_addr_gen u_addr_gen (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .adv       (s_acc),
        .pos       (pos)
    );

    // Row two above: takes the row just above on write back
    frw_line_mem u_upper_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (p1_info_reg.addr),
        .wdata (lower_rdata),
        .re    (s_acc),
        .raddr (pos.addr),
        .rdata (upper_rdata)
    );

    // Row just above: takes the incoming sample on write back
    frw_line_mem u_lower_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (p1_info_reg.addr),
        .wdata (p1_sample_reg),
        .re    (s_acc),
        .raddr (pos.addr),
        .rdata (lower_rdata)
    );

    frw_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .load_p2  (mem_we),
        .top_in   (upper_rdata),
        .mid_in   (lower_rdata),
        .bot_in   (p1_sample_reg),
        .load_out (out_load),
        .zero_out (p2_info_reg.boundary),
        .value    (m_tdata)
    );

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= p1_valid_next;
            p2_valid_reg <= p2_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload along the pipeline
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            p1_sample_reg <= s_tdata;
            p1_info_reg   <= pos;
        end
        if (mem_we)
        begin
            p2_info_reg <= p1_info_reg;
        end
        if (out_load)
        begin
            m_last_reg <= p2_info_reg.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;

    // Read and write back of the line stores never hit the same column
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && mem_we) |-> (pos.addr != p1_info_reg.addr))
        else $error("line store read and write collide on one column");

    // The final coarse point lies on the boundary and reads as zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tdata == '0))
        else $error("final coarse point is not zero");

    // A new result appears only after an emitting sample left the row stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(p2_valid_reg && p2_info_reg.emit))
        else $error("result without an emitting sample");

endmodule

>>> test/full_weighting_restriction_2d_unit_tb.sv
`timescale 1ns / 100ps

module full_weighting_restriction_2d_unit_tb;

    localparam int          CLK_PERIOD     = 10;
    localparam int          RESET_CYCLES   = 5;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned TAIL_CYCLES    = 16;
    localparam int unsigned LONG_HOLD      = 400;
    localparam int unsigned RANDOM_SAMPLES = 500;
    localparam int unsigned RUN_LIMIT_NS   = 5_000_000;

    typedef enum logic [1:0] {
        ITEM_SAMPLE,
        ITEM_REG_WRITE,
        ITEM_DRAIN
    } item_kind_t;

    typedef enum logic [1:0] {
        FILL_MAX,
        FILL_MIN,
        FILL_MIXED
    } fill_style_t;

    typedef struct {
        item_kind_t                 kind;
        logic [frw_pkg::DATA_W-1:0] sample;
        logic                       reg_sel;
        logic [frw_pkg::CFG_W-1:0]  reg_value;
        int unsigned                gap;
    } stim_item_t;

    typedef struct {
        logic [frw_pkg::DATA_W-1:0] value;
        logic                       last;
    } coarse_point_t;

    // DUT ports
    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       cfg_we    = 1'b0;
    logic                       cfg_index = 1'b0;
    logic [frw_pkg::CFG_W-1:0]  cfg_data  = '0;
    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    logic [frw_pkg::DATA_W-1:0] s_tdata   = '0;   // [31:0] sample
    logic                       m_tvalid;
    logic                       m_tready  = 1'b0;
    logic [frw_pkg::DATA_W-1:0] m_tdata;          // [31:0] value
    logic                       m_tlast;

    // Stimulus plan
    stim_item_t                 pending_items[$];
    int unsigned                hold_marks[$];
    int unsigned                sample_total = 0;
    logic [frw_pkg::CFG_W-1:0]  plan_width   = frw_pkg::COARSE_RESET;
    logic [frw_pkg::CFG_W-1:0]  plan_height  = frw_pkg::COARSE_RESET;

    // Driver state
    stim_item_t                 cur_item;
    logic                       item_loaded  = 1'b0;
    int unsigned                gap_left     = 0;
    int unsigned                settle_left  = 0;

    // Receiver state
    int unsigned                ready_wait   = 0;
    int unsigned                hold_left    = 0;

    // Monitor state
    logic                       sample_taken = 1'b0;
    logic                       result_taken = 1'b0;
    int unsigned                samples_seen = 0;
    int unsigned                results_seen = 0;
    int unsigned                fail_count   = 0;

    // Restriction predictor state
    coarse_point_t              coarse_expected[$];
    logic [frw_pkg::CFG_W-1:0]  width_reg  = frw_pkg::COARSE_RESET;
    logic [frw_pkg::CFG_W-1:0]  height_reg = frw_pkg::COARSE_RESET;
    logic signed [35:0]         upper_line [frw_pkg::LINE_DEPTH];
    logic signed [35:0]         lower_line [frw_pkg::LINE_DEPTH];
    logic signed [35:0]         win_col [6];
    int unsigned                col_pos = 0;
    int unsigned                row_pos = 0;

    full_weighting_restriction_2d_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Zero acts as one, anything above the limit acts as the limit
    function automatic int unsigned effective_size(input logic [frw_pkg::CFG_W-1:0] raw,
                                                   input int unsigned limit);
        if (raw == '0)
            return 1;
        if (raw > limit)
            return limit;
        return 32'(raw);
    endfunction

    // Compute the coarse point, if any, caused by one fine sample
    task automatic restrict_sample(input logic [frw_pkg::DATA_W-1:0] raw);
        int unsigned        w;
        int unsigned        h;
        int unsigned        c;
        int unsigned        r;
        int unsigned        crow;
        int unsigned        ccol;
        logic signed [35:0] top;
        logic signed [35:0] mid;
        logic signed [35:0] bot;
        logic signed [35:0] acc;
        logic signed [35:0] shifted;
        coarse_point_t      pt;
        w = effective_size(width_reg, frw_pkg::MAX_COARSE_WIDTH);
        h = effective_size(height_reg, frw_pkg::HEIGHT_LIMIT);
        if (col_pos >= 2 * w)
            col_pos = 0;
        if (row_pos >= 2 * h)
            row_pos = 0;
        c = col_pos;
        r = row_pos;
        top = upper_line[c];
        mid = lower_line[c];
        bot = $signed(raw);

        // Emit on odd row and odd column; boundary points stay zero
        if (r[0] && c[0])
        begin
            crow = r >> 1;
            ccol = c >> 1;
            pt.value = '0;
            if (crow != 0 && crow != h - 1 && ccol != 0 && ccol != w - 1)
            begin
                acc = win_col[0] + 2 * win_col[3] + top
                    + 2 * (win_col[1] + 2 * win_col[4] + mid)
                    + win_col[2] + 2 * win_col[5] + bot;
                shifted = acc >>> 4;
                pt.value = shifted[frw_pkg::DATA_W-1:0];
            end
            pt.last = (crow == h - 1) && (ccol == w - 1);
            coarse_expected.push_back(pt);
        end

        // Shift the window one column and update the line stores
        win_col[0] = win_col[3];
        win_col[1] = win_col[4];
        win_col[2] = win_col[5];
        win_col[3] = top;
        win_col[4] = mid;
        win_col[5] = bot;
        upper_line[c] = mid;
        lower_line[c] = bot;

        // Advance the raster position
        if (c + 1 >= 2 * w)
        begin
            col_pos = 0;
            row_pos = (r + 1 >= 2 * h) ? 0 : r + 1;
        end
        else
        begin
            col_pos = c + 1;
        end
    endtask

    function automatic logic [frw_pkg::DATA_W-1:0] draw_sample(input fill_style_t fill);
        logic [frw_pkg::DATA_W-1:0] raw_bits;
        raw_bits = $urandom();
        if (fill == FILL_MAX)
            return 32'h7FFF_FFFF;
        if (fill == FILL_MIN)
            return 32'h8000_0000;
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return {{(frw_pkg::DATA_W - 8){raw_bits[7]}}, raw_bits[7:0]};
            default: return raw_bits;
        endcase
    endfunction

    function automatic logic [frw_pkg::CFG_W-1:0] draw_size_raw();
        case ($urandom_range(0, 15))
            0: return '0;
            1: return $urandom_range(0, 1) ? frw_pkg::CFG_W'(512)
                                           : frw_pkg::CFG_W'($urandom_range(513, 1023));
            2: return frw_pkg::CFG_W'(1023);
            default: return frw_pkg::CFG_W'($urandom_range(1, 8));
        endcase
    endfunction

    task automatic add_sample(input logic [frw_pkg::DATA_W-1:0] v);
        stim_item_t it;
        it.kind      = ITEM_SAMPLE;
        it.sample    = v;
        it.reg_sel   = frw_pkg::REG_COARSE_WIDTH;
        it.reg_value = '0;
        // Every fourth stretch of 128 samples runs without gaps
        it.gap       = ((sample_total / 128) % 4 == 3) ? 0 : $urandom_range(0, 9);
        pending_items.push_back(it);
        sample_total++;
    endtask

    task automatic add_random_samples(input int unsigned count, input fill_style_t fill);
        for (int unsigned k = 0; k < count; k++)
            add_sample(draw_sample(fill));
    endtask

    task automatic add_reg_write(input logic sel, input logic [frw_pkg::CFG_W-1:0] value);
        stim_item_t it;
        it.kind      = ITEM_REG_WRITE;
        it.sample    = '0;
        it.reg_sel   = sel;
        it.reg_value = value;
        it.gap       = 0;
        pending_items.push_back(it);
        if (sel == frw_pkg::REG_COARSE_WIDTH)
            plan_width = value;
        else
            plan_height = value;
    endtask

    task automatic add_drain();
        stim_item_t it;
        it.kind      = ITEM_DRAIN;
        it.sample    = '0;
        it.reg_sel   = frw_pkg::REG_COARSE_WIDTH;
        it.reg_value = '0;
        it.gap       = 0;
        pending_items.push_back(it);
    endtask

    // Driver: present samples and register writes at the falling edge
    always @(negedge clk)
    begin : drive_step
        logic                       valid_nxt;
        logic                       we_nxt;
        logic                       sel_nxt;
        logic [frw_pkg::DATA_W-1:0] data_nxt;
        logic [frw_pkg::CFG_W-1:0]  value_nxt;
        if (rst_n)
        begin
            valid_nxt = s_tvalid;
            we_nxt    = 1'b0;
            sel_nxt   = cfg_index;
            data_nxt  = s_tdata;
            value_nxt = cfg_data;
            // Drop valid once the transaction has gone through
            if (s_tvalid && sample_taken)
                valid_nxt = 1'b0;
            if (!valid_nxt)
            begin
                if (!item_loaded && pending_items.size() > 0)
                begin
                    cur_item    = pending_items.pop_front();
                    item_loaded = 1'b1;
                    gap_left    = cur_item.gap;
                    settle_left = SETTLE_CYCLES;
                end
                if (item_loaded)
                begin
                    if (cur_item.kind == ITEM_SAMPLE)
                    begin
                        if (gap_left > 0)
                        begin
                            gap_left--;
                        end
                        else
                        begin
                            valid_nxt   = 1'b1;
                            data_nxt    = cur_item.sample;
                            item_loaded = 1'b0;
                        end
                    end
                    else if (coarse_expected.size() > 0)
                    begin
                        // Hold until every coarse point is out
                        settle_left = SETTLE_CYCLES;
                    end
                    else if (settle_left > 0)
                    begin
                        // Let samples that emit nothing leave the pipeline
                        settle_left--;
                    end
                    else
                    begin
                        if (cur_item.kind == ITEM_REG_WRITE)
                        begin
                            we_nxt    = 1'b1;
                            sel_nxt   = cur_item.reg_sel;
                            value_nxt = cur_item.reg_value;
                        end
                        item_loaded = 1'b0;
                    end
                end
            end
            s_tvalid  <= valid_nxt;
            s_tdata   <= data_nxt;
            cfg_we    <= we_nxt;
            cfg_index <= sel_nxt;
            cfg_data  <= value_nxt;
        end
    end

    // Receiver: random ready gaps plus long hold-offs at planned points
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_marks.size() > 0 && samples_seen >= hold_marks[0])
            begin
                void'(hold_marks.pop_front());
                hold_left = LONG_HOLD;
            end
            if (result_taken)
                ready_wait = ((results_seen / 64) % 4 == 3) ? 0 : $urandom_range(0, 9);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (ready_wait > 0)
            begin
                ready_wait--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Monitor: check outputs, then advance the predictor
    always @(posedge clk)
    begin : watch_step
        coarse_point_t want;
        if (rst_n)
        begin
            sample_taken = s_tvalid && s_tready;
            result_taken = m_tvalid && m_tready;
            if (result_taken)
            begin
                results_seen++;
                if (coarse_expected.size() == 0)
                begin
                    $error("unexpected coarse point: value %h last %b", m_tdata, m_tlast);
                    fail_count++;
                end
                else
                begin
                    want = coarse_expected.pop_front();
                    if (m_tdata !== want.value)
                    begin
                        $error("value mismatch: expected %h, actual %h", want.value, m_tdata);
                        fail_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last mismatch: expected %b, actual %b", want.last, m_tlast);
                        fail_count++;
                    end
                end
            end
            if (sample_taken)
            begin
                samples_seen++;
                restrict_sample(s_tdata);
            end
            // Any register write restarts the frame
            if (cfg_we)
            begin
                if (cfg_index == frw_pkg::REG_COARSE_WIDTH)
                    width_reg = cfg_data;
                else
                    height_reg = cfg_data;
                col_pos = 0;
                row_pos = 0;
            end
        end
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int unsigned               random_count;
        int unsigned               frame_len;
        int unsigned               count;
        logic [frw_pkg::CFG_W-1:0] pick_w;
        logic [frw_pkg::CFG_W-1:0] pick_h;
        fill_style_t               fill;

        for (int k = 0; k < frw_pkg::LINE_DEPTH; k++)
        begin
            upper_line[k] = '0;
            lower_line[k] = '0;
        end
        for (int k = 0; k < 6; k++)
            win_col[k] = '0;

        // Two frames at the reset sizes
        add_random_samples(2 * 4 * frw_pkg::COARSE_RESET * frw_pkg::COARSE_RESET, FILL_MIXED);

        // Zero sizes act as one: a 2x2 fine frame of extreme samples
        add_reg_write(frw_pkg::REG_COARSE_WIDTH, '0);
        add_reg_write(frw_pkg::REG_COARSE_HEIGHT, '0);
        add_sample(32'h7FFF_FFFF);
        add_sample(32'h8000_0000);
        add_sample(32'h0000_0000);
        add_sample(32'hFFFF_FFFF);

        // 3x3 coarse: most negative window around the one interior point,
        // cut short so the next write restarts the frame
        add_reg_write(frw_pkg::REG_COARSE_WIDTH, frw_pkg::CFG_W'(3));
        add_reg_write(frw_pkg::REG_COARSE_HEIGHT, frw_pkg::CFG_W'(3));
        for (int unsigned k = 0; k < 22; k++)
        begin
            if (k / 6 >= 1 && k / 6 <= 3 && k % 6 >= 1 && k % 6 <= 3)
                add_sample(32'h8000_0000);
            else
                add_sample(32'h7FFF_FFFF);
        end

        // Random phases, mostly small sizes and whole frames
        random_count = 0;
        while (random_count < RANDOM_SAMPLES)
        begin
            pick_w = draw_size_raw();
            pick_h = draw_size_raw();
            case ($urandom_range(0, 3))
                0: add_reg_write(frw_pkg::REG_COARSE_WIDTH, pick_w);
                1: add_reg_write(frw_pkg::REG_COARSE_HEIGHT, pick_h);
                default:
                begin
                    add_reg_write(frw_pkg::REG_COARSE_WIDTH, pick_w);
                    add_reg_write(frw_pkg::REG_COARSE_HEIGHT, pick_h);
                end
            endcase
            frame_len = 4 * effective_size(plan_width, frw_pkg::MAX_COARSE_WIDTH)
                          * effective_size(plan_height, frw_pkg::HEIGHT_LIMIT);
            if (frame_len > 256)
                count = $urandom_range(1, 64);
            else if ($urandom_range(0, 4) != 0)
                count = frame_len * $urandom_range(1, 3);
            else
                count = $urandom_range(1, 2 * frame_len);
            case ($urandom_range(0, 7))
                0: fill = FILL_MAX;
                1: fill = FILL_MIN;
                default: fill = FILL_MIXED;
            endcase
            add_random_samples(count, fill);
            random_count += count;
        end

        // Widest grid: one clamped fine row and the start of the next,
        // a long output stall among the emitting samples and a full drain
        add_reg_write(frw_pkg::REG_COARSE_WIDTH, frw_pkg::CFG_W'(1023));
        add_reg_write(frw_pkg::REG_COARSE_HEIGHT, frw_pkg::CFG_W'(1));
        hold_marks.push_back(sample_total + frw_pkg::LINE_DEPTH + 8);
        add_random_samples(frw_pkg::LINE_DEPTH + 96, FILL_MIXED);
        add_drain();
        add_random_samples(32, FILL_MIXED);

        // Reset sequence
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for every transaction to be offered and taken, then drain
        while (pending_items.size() > 0 || item_loaded || s_tvalid)
            @(posedge clk);
        while (coarse_expected.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && coarse_expected.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
